>>> src/dwr_pkg.sv
// Shared types, constants and the answer record table for the wildcard DNS responder.
// No dependencies; imported by dwr_cfg, dwr_parse, dwr_emit and the top level.
package dwr_pkg;

  localparam int unsigned MAX_PACKET_DEF = 512;
  localparam int unsigned HDR_LEN        = 12;
  localparam int unsigned ANS_LEN        = 16;
  localparam int unsigned QTAIL_LEN      = 4;

  localparam logic [7:0]  FLAGS_HI       = 8'h84;
  localparam logic [7:0]  PTR_HI         = 8'hC0;
  localparam logic [7:0]  PTR_LO         = 8'h0C;
  localparam logic [31:0] ADDR_RESET     = 32'hC0A8_0401;
  localparam logic [31:0] TTL_RESET      = 32'd300;

  // register indexes on the configuration port
  localparam logic REG_ADDRESS = 1'b0;
  localparam logic REG_TTL     = 1'b1;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_ANSWER,
    TAIL_DISCARD
  } tail_kind_t;

  // work handed from the parser to the emitter for one accepted byte
  typedef struct packed {
    logic       echo;
    logic [7:0] echo_byte;
    tail_kind_t tail;
  } job_t;

  function automatic logic [7:0] ans_byte(input logic [3:0] idx, input logic [31:0] ttl,
                                          input logic [31:0] addr);
    logic [7:0] b;
    case (idx)
      4'd0:    b = PTR_HI;
      4'd1:    b = PTR_LO;
      4'd2:    b = 8'h00;
      4'd3:    b = 8'h01;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h01;
      4'd6:    b = ttl[31:24];
      4'd7:    b = ttl[23:16];
      4'd8:    b = ttl[15:8];
      4'd9:    b = ttl[7:0];
      4'd10:   b = 8'h00;
      4'd11:   b = 8'h04;
      4'd12:   b = addr[31:24];
      4'd13:   b = addr[23:16];
      4'd14:   b = addr[15:8];
      default: b = addr[7:0];
    endcase
    return b;
  endfunction

endpackage

>>> src/dwr_cfg.sv
// Configuration registers (answer address and TTL) behind an APB-style port.
// Depends on dwr_pkg for reset values and register indexes.
module dwr_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] answer_address,
  output logic [31:0] answer_ttl
);
  import dwr_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_address <= ADDR_RESET;
      answer_ttl     <= TTL_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_ADDRESS: answer_address <= pwdata;
        REG_TTL:     answer_ttl     <= pwdata;
        default:     answer_address <= answer_address;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ADDRESS: prdata = answer_address;
      REG_TTL:     prdata = answer_ttl;
      default:     prdata = '0;
    endcase
  end

endmodule

>>> src/dwr_parse.sv
// Query parser: rewrites the header, walks the question labels and decides the tail.
// Depends on dwr_pkg for the job struct and constants.
module dwr_parse #(
  parameter int unsigned MAX_PACKET = dwr_pkg::MAX_PACKET_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  input  logic          end_of_datagram,
  output dwr_pkg::job_t job
);
  import dwr_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_PACKET + 1);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_LABEL,
    PH_TAIL,
    PH_DONE
  } phase_t;

  phase_t          parse_phase, parse_phase_next;
  logic [PosW-1:0] byte_position, byte_position_next;
  logic [7:0]      label_remaining, label_remaining_next;
  logic [2:0]      tail_remaining, tail_remaining_next;
  logic [PosW-1:0] question_end, question_end_next;

  logic            in_range;
  logic [7:0]      out_b;
  logic [7:0]      lab_dec;
  logic [2:0]      tail_dec;
  logic            fits;

  assign in_range = byte_position < PosW'(MAX_PACKET);
  assign lab_dec  = (label_remaining != 8'd0) ? label_remaining - 8'd1 : label_remaining;
  assign tail_dec = (tail_remaining != 3'd0) ? tail_remaining - 3'd1 : tail_remaining;

  always_comb begin
    parse_phase_next     = parse_phase;
    byte_position_next   = byte_position;
    label_remaining_next = label_remaining;
    tail_remaining_next  = tail_remaining;
    question_end_next    = question_end;
    out_b                = rx_byte;

    if (in_range) begin
      byte_position_next = byte_position + PosW'(1);
      unique case (parse_phase)
        PH_HEADER: begin
          if (byte_position == PosW'(2)) begin
            out_b = FLAGS_HI;
          end else if (byte_position == PosW'(7)) begin
            out_b = 8'h01;
          end else if (byte_position == PosW'(3) || byte_position == PosW'(6) ||
                       (byte_position >= PosW'(8) && byte_position <= PosW'(HDR_LEN - 1))) begin
            out_b = 8'h00;
          end
          if (byte_position == PosW'(HDR_LEN - 1)) parse_phase_next = PH_NAME;
        end
        PH_NAME: begin
          if (rx_byte == 8'd0) begin
            parse_phase_next    = PH_TAIL;
            tail_remaining_next = 3'(QTAIL_LEN);
          end else begin
            parse_phase_next     = PH_LABEL;
            label_remaining_next = rx_byte;
          end
        end
        PH_LABEL: begin
          label_remaining_next = lab_dec;
          if (lab_dec == 8'd0) parse_phase_next = PH_NAME;
        end
        PH_TAIL: begin
          tail_remaining_next = tail_dec;
          if (tail_dec == 3'd0) begin
            parse_phase_next  = PH_DONE;
            question_end_next = byte_position + PosW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign fits = ({1'b0, question_end_next} + (PosW + 1)'(ANS_LEN)) <= (PosW + 1)'(MAX_PACKET);

  always_comb begin
    job.echo      = in_range && (parse_phase != PH_DONE);
    job.echo_byte = out_b;
    if (!end_of_datagram) begin
      job.tail = TAIL_NONE;
    end else if (parse_phase_next == PH_DONE && fits) begin
      job.tail = TAIL_ANSWER;
    end else begin
      job.tail = TAIL_DISCARD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_HEADER;
      byte_position   <= '0;
      label_remaining <= '0;
      tail_remaining  <= '0;
      question_end    <= '0;
    end else if (accept) begin
      if (end_of_datagram) begin
        // datagram closed: start over for the next one
        parse_phase     <= PH_HEADER;
        byte_position   <= '0;
        label_remaining <= '0;
        tail_remaining  <= '0;
        question_end    <= '0;
      end else begin
        parse_phase     <= parse_phase_next;
        byte_position   <= byte_position_next;
        label_remaining <= label_remaining_next;
        tail_remaining  <= tail_remaining_next;
        question_end    <= question_end_next;
      end
    end
  end

endmodule

>>> src/dwr_emit.sv
// Result emitter: holds one job, sends its echo byte (if any) then any answer burst or discard marker.
// Depends on dwr_pkg for the job struct and the answer table.
module dwr_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  dwr_pkg::job_t job_in,
  input  logic [31:0]   answer_address,
  input  logic [31:0]   answer_ttl,
  output logic          can_load,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    reply_byte,
  output logic          end_of_reply,
  output logic          discard
);
  import dwr_pkg::*;

  job_t       job;
  logic [3:0] ans_idx;

  logic       busy;
  logic       out_ready;
  logic       take;
  logic       last_one;
  logic [7:0] nxt_byte;
  logic       nxt_eor;
  logic       nxt_disc;

  assign busy      = job.echo || (job.tail != TAIL_NONE);
  assign out_ready = !out_valid || !out_stall;
  assign take      = busy && out_ready;

  always_comb begin
    if (job.echo) begin
      last_one = (job.tail == TAIL_NONE);
    end else begin
      last_one = (job.tail == TAIL_DISCARD) || (ans_idx == 4'(ANS_LEN - 1));
    end
  end

  // a new transaction may enter when no job is held or the held job drains this cycle
  assign can_load = !busy || (take && last_one);

  always_comb begin
    if (job.echo) begin
      nxt_byte = job.echo_byte;
      nxt_eor  = 1'b0;
      nxt_disc = 1'b0;
    end else if (job.tail == TAIL_ANSWER) begin
      nxt_byte = ans_byte(ans_idx, answer_ttl, answer_address);
      nxt_eor  = (ans_idx == 4'(ANS_LEN - 1));
      nxt_disc = 1'b0;
    end else begin
      nxt_byte = 8'h00;
      nxt_eor  = 1'b1;
      nxt_disc = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job.echo  <= 1'b0;
      job.tail  <= TAIL_NONE;
      ans_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        job.echo      <= job_in.echo;
        job.echo_byte <= job_in.echo_byte;
        job.tail      <= job_in.tail;
        ans_idx       <= '0;
      end else if (take) begin
        if (job.echo) begin
          job.echo <= 1'b0;
        end else if (job.tail == TAIL_ANSWER && ans_idx != 4'(ANS_LEN - 1)) begin
          ans_idx <= ans_idx + 4'd1;
        end else begin
          job.tail <= TAIL_NONE;
        end
      end
      if (out_ready) out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      reply_byte   <= nxt_byte;
      end_of_reply <= nxt_eor;
      discard      <= nxt_disc;
    end
  end

endmodule

>>> src/dns_wildcard_a_responder_top.sv
// Wildcard DNS A responder: one query byte per cycle in, one reply byte per cycle out, unless
// in_stall or out_stall holds the flow. An accepted byte is parsed in the cycle it arrives and
// its echo passes through the emitter's job register and then the output register. Bytes
// are taken one per cycle while in_stall is low; the last byte of a datagram holds the input
// while its answer record or discard marker drains, since the single output register
// sends one result byte per cycle when not stalled. Bytes beyond MAX_PACKET are accepted and
// produce no echo. Depends on dwr_pkg, dwr_cfg, dwr_parse and dwr_emit.
module dns_wildcard_a_responder_top #(
  parameter int unsigned MAX_PACKET = dwr_pkg::MAX_PACKET_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_datagram,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  reply_byte,
  output logic        end_of_reply,
  output logic        discard,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dwr_pkg::*;

  job_t        job;
  logic        can_load;
  logic        accept;
  logic [31:0] answer_address;
  logic [31:0] answer_ttl;

  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;

  dwr_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .answer_address (answer_address),
    .answer_ttl     (answer_ttl)
  );

  dwr_parse #(.MAX_PACKET(MAX_PACKET)) u_parse (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .rx_byte         (rx_byte),
    .end_of_datagram (end_of_datagram),
    .job             (job)
  );

  dwr_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .load           (accept),
    .job_in         (job),
    .answer_address (answer_address),
    .answer_ttl     (answer_ttl),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .reply_byte     (reply_byte),
    .end_of_reply   (end_of_reply),
    .discard        (discard)
  );

endmodule

>>> src/dwr_checker.sv
// Port-level checks for the wildcard DNS responder, bound to the top level.
// Depends only on the top level's ports.
module dwr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] reply_byte,
  input logic       end_of_reply,
  input logic       discard,
  input logic       pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(reply_byte) &&
                               $stable(end_of_reply) && $stable(discard))
    else $error("stalled result changed");

  // the discard marker is always a lone zero byte that closes the reply
  a_discard_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && discard |-> end_of_reply && reply_byte == 8'h00)
    else $error("malformed discard marker");

  // nothing leaves the block in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown straight after reset");

  // configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind dns_wildcard_a_responder_top dwr_checker u_dwr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .reply_byte   (reply_byte),
  .end_of_reply (end_of_reply),
  .discard      (discard),
  .pready       (pready)
);
